>>> rtl/core/htvt_pkg.sv
// ----------------------------------------------------------------------------
// htvt_pkg: shared types and constants of the hot target value tracker
// Defaults, beat structs and sequencer state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package htvt_pkg;

    localparam int NumSitesDef      = 256;
    localparam int SteadyEntriesDef = 6;
    localparam int ClearEntriesDef  = 4;
    localparam int CountWidthDef    = 32;

    localparam logic [1:0] PlcSteady  = 2'd0;
    localparam logic [1:0] PlcClear   = 2'd1;
    localparam logic [1:0] PlcDropped = 2'd2;

    typedef struct packed {
        logic [7:0]  site_id;
        logic [63:0] target_value;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] exec_count;
        logic [63:0] top_value;
        logic [31:0] top_count;
        logic [1:0]  placement;
        logic        merged;
    } t_out_beat;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_MERGE,
        ST_PLACE,
        ST_WRITE,
        ST_OUT
    } t_state;

endpackage

`default_nettype wire

>>> rtl/core/htvt_site_mem.sv
// ----------------------------------------------------------------------------
// htvt_site_mem: per-site record memory
// One record per site: exec count, clear count, values and counts.
// ----------------------------------------------------------------------------
`default_nettype none

module htvt_site_mem #(
    parameter int NumSites = htvt_pkg::NumSitesDef,
    parameter int RecW     = 64,
    parameter int AddrW    = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AddrW-1:0] i_waddr,
    input  wire logic [RecW-1:0]  i_wdata,
    input  wire logic [AddrW-1:0] i_raddr,
    output logic      [RecW-1:0]  o_rdata
);
    logic [RecW-1:0] r_mem [NumSites];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

`default_nettype wire

>>> rtl/core/htvt_cmp_unit.sv
// ----------------------------------------------------------------------------
// htvt_cmp_unit: shared compare unit
// One count compare and one value match per cycle for the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module htvt_cmp_unit #(
    parameter int CountW = htvt_pkg::CountWidthDef
) (
    input  wire logic [CountW-1:0] i_ca,
    input  wire logic [CountW-1:0] i_cb,
    input  wire logic [63:0]       i_va,
    input  wire logic [63:0]       i_vb,
    output logic                   o_ge,
    output logic                   o_lt,
    output logic                   o_match
);
    assign o_ge    = i_ca >= i_cb;
    assign o_lt    = i_ca < i_cb;
    assign o_match = (i_va == i_vb);
endmodule

`default_nettype wire

>>> rtl/core/hot_target_value_tracker.sv
// ----------------------------------------------------------------------------
// hot_target_value_tracker: per-site top-N value profiling table
// Sequenced read-modify-write of one site record per beat.
// ----------------------------------------------------------------------------
// Each input beat names a site and a 64-bit value. The site record (exec and
// clear counters plus STEADY_ENTRIES + CLEAR_ENTRIES sorted value/count
// pairs) lives in one wide single-port-write memory. A small sequencer reads
// the record, optionally merges the two parts (one output entry per cycle
// through the shared compare unit), scans for a match or empty slot (one
// entry per cycle), bubbles a match up (one swap per cycle), writes back and
// presents the result. A beat passes accept, read, load, the optional merge,
// scan, bubble, writeback and result, in that order. The scan visits every
// entry up to the deciding one, with a step more to cross into the clear
// part and another when the value is dropped; the bubble ends with one
// closing compare after its swaps. A merge fills the STEADY_ENTRIES temp
// entries, then copies them back. Writeback waits while the previous result
// beat is still not taken. After reset a clearing pass zeroes all NUM_SITES
// records before the first beat is taken. The block takes one beat at a
// time; the result register frees as soon as the output beat is taken.
`default_nettype none

module hot_target_value_tracker #(
    parameter int NUM_SITES      = htvt_pkg::NumSitesDef,
    parameter int STEADY_ENTRIES = htvt_pkg::SteadyEntriesDef,
    parameter int CLEAR_ENTRIES  = htvt_pkg::ClearEntriesDef,
    parameter int COUNT_WIDTH    = htvt_pkg::CountWidthDef
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire htvt_pkg::t_in_beat  i_data,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output htvt_pkg::t_out_beat      o_data
);
    import htvt_pkg::*;

    localparam int Total  = STEADY_ENTRIES + CLEAR_ENTRIES;
    localparam int CW     = COUNT_WIDTH;
    localparam int AddrW  = (NUM_SITES > 1) ? $clog2(NUM_SITES) : 1;
    localparam int IdxW   = $clog2(Total + 1);
    localparam int SIdxW  = (STEADY_ENTRIES > 1) ? $clog2(STEADY_ENTRIES) : 1;
    localparam int RecW   = 2 * CW + Total * (64 + CW);
    localparam int MidA   = STEADY_ENTRIES / 2;
    localparam int MidB   = STEADY_ENTRIES / 2 + 1;
    localparam logic [CW-1:0] CntMax = '1;
    localparam logic [IdxW-1:0] IdxSteady = IdxW'(STEADY_ENTRIES);
    localparam logic [IdxW-1:0] IdxTotal  = IdxW'(Total);

    // working copy of one record
    logic [CW-1:0] r_exec, n_exec, r_clr, n_clr;
    logic [63:0]   r_v [Total];
    logic [CW-1:0] r_c [Total];
    logic [63:0]   n_v [Total];
    logic [CW-1:0] n_c [Total];
    logic [63:0]   r_tv [STEADY_ENTRIES];
    logic [CW-1:0] r_tc [STEADY_ENTRIES];
    logic [63:0]   n_tv [STEADY_ENTRIES];
    logic [CW-1:0] n_tc [STEADY_ENTRIES];

    t_state r_state, n_state;
    logic [AddrW-1:0] r_site, n_site, r_clr_addr, n_clr_addr;
    logic [63:0]      r_val, n_val;
    logic [IdxW-1:0]  r_i, n_i, r_a, n_a, r_b, n_b, r_k, n_k;
    logic             r_lo_part, n_lo_part;   // 0 steady scan, 1 clear scan
    logic             r_bub, n_bub;
    logic             r_merged, n_merged;
    logic [1:0]       r_plc, n_plc;
    logic             r_ov, n_ov;
    t_out_beat        r_od, n_od;

    // memory
    logic             mem_we;
    logic [AddrW-1:0] mem_waddr;
    logic [RecW-1:0]  mem_wdata, mem_rdata;

    htvt_site_mem #(.NumSites(NUM_SITES), .RecW(RecW), .AddrW(AddrW)) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(r_site),
        .o_rdata(mem_rdata)
    );

    // shared compare unit
    logic [CW-1:0] cu_ca, cu_cb;
    logic [63:0]   cu_va, cu_vb;
    logic          cu_ge, cu_lt, cu_match;

    htvt_cmp_unit #(.CountW(CW)) u_cmp (
        .i_ca(cu_ca), .i_cb(cu_cb), .i_va(cu_va), .i_vb(cu_vb),
        .o_ge(cu_ge), .o_lt(cu_lt), .o_match(cu_match)
    );

    // record packing
    always_comb begin
        mem_wdata = '0;
        mem_wdata[CW-1:0]    = r_exec;
        mem_wdata[2*CW-1:CW] = r_clr;
        for (int e = 0; e < Total; e++) begin
            mem_wdata[2*CW + e*(64+CW) +: 64] = r_v[e];
            mem_wdata[2*CW + e*(64+CW) + 64 +: CW] = r_c[e];
        end
    end

    logic [CW-1:0] rd_exec, rd_clr, exec_inc, clr_inc, ma, mb;
    logic [CW:0]   mid_sum;
    always_comb begin
        rd_exec  = mem_rdata[CW-1:0];
        rd_clr   = mem_rdata[2*CW-1:CW];
        exec_inc = (rd_exec == CntMax) ? CntMax : rd_exec + 1'b1;
        clr_inc  = (rd_clr == CntMax) ? CntMax : rd_clr + 1'b1;
        ma = (MidA < STEADY_ENTRIES) ? mem_rdata[2*CW + (MidA % Total)*(64+CW) + 64 +: CW]
                                     : '0;
        mb = (MidB < STEADY_ENTRIES) ? mem_rdata[2*CW + (MidB % Total)*(64+CW) + 64 +: CW]
                                     : '0;
        mid_sum = {1'b0, ma} + {1'b0, mb};
    end

    // r_a and r_b are range-guarded here; r_i is not and reaches Total at scan end
    logic [CW-1:0] c_i, c_im1, c_a, c_b;
    logic [63:0]   v_i;
    always_comb begin
        c_i   = r_c[r_i];
        v_i   = r_v[r_i];
        c_im1 = (r_i != '0) ? r_c[r_i - 1'b1] : '0;
        c_a   = (r_a < IdxSteady) ? r_c[r_a] : '0;
        c_b   = (r_b < IdxTotal) ? r_c[r_b] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_ov       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_ov       <= n_ov;
        end
        r_exec <= n_exec; r_clr <= n_clr; r_site <= n_site; r_val <= n_val;
        r_i <= n_i; r_a <= n_a; r_b <= n_b; r_k <= n_k;
        r_lo_part <= n_lo_part; r_bub <= n_bub; r_merged <= n_merged;
        r_plc <= n_plc; r_od <= n_od;
        for (int e = 0; e < Total; e++) begin
            r_v[e] <= n_v[e];
            r_c[e] <= n_c[e];
        end
        for (int e = 0; e < STEADY_ENTRIES; e++) begin
            r_tv[e] <= n_tv[e];
            r_tc[e] <= n_tc[e];
        end
    end

    always_comb begin
        n_state = r_state; n_clr_addr = r_clr_addr; n_ov = r_ov; n_od = r_od;
        n_exec = r_exec; n_clr = r_clr; n_site = r_site; n_val = r_val;
        n_i = r_i; n_a = r_a; n_b = r_b; n_k = r_k;
        n_lo_part = r_lo_part; n_bub = r_bub; n_merged = r_merged; n_plc = r_plc;
        for (int e = 0; e < Total; e++) begin
            n_v[e] = r_v[e];
            n_c[e] = r_c[e];
        end
        for (int e = 0; e < STEADY_ENTRIES; e++) begin
            n_tv[e] = r_tv[e];
            n_tc[e] = r_tc[e];
        end
        mem_we = 1'b0; mem_waddr = r_site;
        cu_ca = c_i; cu_cb = c_im1; cu_va = v_i; cu_vb = r_val;
        o_ready = 1'b0;
        if (r_ov && i_ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            ST_CLEAR: begin
                // zero record written from r_* which are cleared below
                n_exec = '0; n_clr = '0;
                for (int e = 0; e < Total; e++) begin
                    n_v[e] = '0;
                    n_c[e] = '0;
                end
                mem_we    = (r_exec == '0) && (r_clr == '0);
                mem_waddr = r_clr_addr;
                for (int e = 0; e < Total; e++) begin
                    if (r_c[e] != '0 || r_v[e] != '0) begin
                        mem_we = 1'b0;
                    end
                end
                if (mem_we) begin
                    n_clr_addr = r_clr_addr + 1'b1;
                    if (r_clr_addr == AddrW'(NUM_SITES - 1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_site  = AddrW'(32'(i_data.site_id) % NUM_SITES);
                    n_val   = i_data.target_value;
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_LOAD;  // memory read in flight
            end
            ST_LOAD: begin
                n_exec = exec_inc;
                for (int e = 0; e < Total; e++) begin
                    n_v[e] = mem_rdata[2*CW + e*(64+CW) +: 64];
                    n_c[e] = mem_rdata[2*CW + e*(64+CW) + 64 +: CW];
                end
                n_a = '0; n_b = IdxSteady; n_k = '0;
                n_i = '0; n_lo_part = 1'b0; n_bub = 1'b0;
                if ({1'b0, clr_inc} >= mid_sum) begin
                    n_clr = '0; n_merged = 1'b1; n_state = ST_MERGE;
                end else begin
                    n_clr = clr_inc; n_merged = 1'b0; n_state = ST_PLACE;
                end
            end
            ST_MERGE: begin
                // one merged entry per cycle into the temp row
                cu_ca = c_a; cu_cb = c_b;
                if (r_k == IdxSteady) begin
                    for (int e = 0; e < STEADY_ENTRIES; e++) begin
                        n_v[e] = r_tv[e];
                        n_c[e] = r_tc[e];
                    end
                    for (int e = STEADY_ENTRIES; e < Total; e++) begin
                        n_v[e] = '0;
                        n_c[e] = '0;
                    end
                    n_state = ST_PLACE;
                end else begin
                    if (r_b >= IdxTotal || (r_a < IdxSteady && cu_ge)) begin
                        n_tv[r_k[SIdxW-1:0]] = r_v[r_a];
                        n_tc[r_k[SIdxW-1:0]] = r_c[r_a];
                        n_a = r_a + 1'b1;
                    end else begin
                        n_tv[r_k[SIdxW-1:0]] = r_v[r_b];
                        n_tc[r_k[SIdxW-1:0]] = r_c[r_b];
                        n_b = r_b + 1'b1;
                    end
                    n_k = r_k + 1'b1;
                end
            end
            ST_PLACE: begin
                if (r_bub) begin
                    // move up past smaller counts, one swap a cycle
                    if (r_i != (r_lo_part ? IdxSteady : '0) && cu_lt) begin
                        n_v[r_i - 1'b1] = r_v[r_i];
                        n_c[r_i - 1'b1] = r_c[r_i];
                        n_v[r_i] = r_v[r_i - 1'b1];
                        n_c[r_i] = r_c[r_i - 1'b1];
                        n_i = r_i - 1'b1;
                        cu_ca = c_im1; cu_cb = c_i;
                    end else begin
                        n_state = ST_WRITE;
                    end
                    cu_ca = c_im1; cu_cb = c_i;
                end else if ((!r_lo_part && r_i == IdxSteady) ||
                             (r_lo_part && r_i == IdxTotal)) begin
                    if (!r_lo_part) begin
                        n_lo_part = 1'b1;
                    end else begin
                        n_plc = PlcDropped; n_state = ST_WRITE;
                    end
                end else if (c_i != '0 && cu_match) begin
                    n_c[r_i] = (c_i == CntMax) ? CntMax : c_i + 1'b1;
                    n_plc = r_lo_part ? PlcClear : PlcSteady;
                    n_bub = 1'b1;
                end else if (c_i == '0) begin
                    n_v[r_i] = r_val;
                    n_c[r_i] = CW'(1);
                    n_plc = r_lo_part ? PlcClear : PlcSteady;
                    n_state = ST_WRITE;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            ST_WRITE: begin
                mem_we = 1'b1;
                if (!r_ov || i_ready) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                n_ov = 1'b1;
                n_od.exec_count = 32'(r_exec);
                n_od.top_value  = r_v[0];
                n_od.top_count  = 32'(r_c[0]);
                n_od.placement  = r_plc;
                n_od.merged     = r_merged;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_valid = r_ov;
    assign o_data  = r_od;

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_ready)
        else $error("ready while busy");
    a_plc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.placement != 2'd3))
        else $error("bad placement code");
    a_out_after_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) |-> $past(r_state == ST_WRITE))
        else $error("result without writeback");
`endif
endmodule

`default_nettype wire

>>> tb/sv/hot_target_value_tracker_tb.sv
// ----------------------------------------------------------------------------
// hot_target_value_tracker_tb: self-checking bench of the value tracker
// Drives site/value beats with random gaps, predicts each result beat from a
// private copy of every site record and compares field by field, in order.
// ----------------------------------------------------------------------------
`default_nettype none

module hot_target_value_tracker_tb;
    import htvt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int Sites   = NumSitesDef;
    localparam int Steady  = SteadyEntriesDef;
    localparam int Entries = SteadyEntriesDef + ClearEntriesDef;
    localparam logic [31:0] CountMax = 32'hFFFF_FFFF;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_in_beat  i_data = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_out_beat o_data;

    hot_target_value_tracker dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_data (o_data)
    );

    always #6 i_clk = ~i_clk;

    // Mirror of the site store: counters plus steady and clear entries.
    logic [31:0] exec_cnt [Sites];
    logic [31:0] clear_cnt[Sites];
    logic [63:0] ent_val  [Sites][Entries];
    logic [31:0] ent_cnt  [Sites][Entries];

    t_in_beat  send_q[$];     // beats waiting for the driver
    t_out_beat result_q[$];   // predicted result beats, oldest first
    int        errors = 0;
    bit        quiet = 1'b0;  // no idling on either side when set

    function automatic logic [31:0] sat_inc(logic [31:0] c);
        return (c == CountMax) ? c : c + 32'd1;
    endfunction

    // Match or fill the first empty slot in [lo, hi); a match bubbles up.
    function automatic bit place_value(int s, int lo, int hi, logic [63:0] val);
        int          j;
        logic [63:0] tv;
        logic [31:0] tc;
        for (int i = lo; i < hi; i++) begin
            if (ent_cnt[s][i] != 0 && ent_val[s][i] == val) begin
                ent_cnt[s][i] = sat_inc(ent_cnt[s][i]);
                j = i;
                while (j > lo && ent_cnt[s][j-1] < ent_cnt[s][j]) begin
                    tv = ent_val[s][j-1]; ent_val[s][j-1] = ent_val[s][j];
                    ent_val[s][j] = tv;
                    tc = ent_cnt[s][j-1]; ent_cnt[s][j-1] = ent_cnt[s][j];
                    ent_cnt[s][j] = tc;
                    j--;
                end
                return 1'b1;
            end
            if (ent_cnt[s][i] == 0) begin
                ent_val[s][i] = val;
                ent_cnt[s][i] = 32'd1;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Merge both sorted parts by count, steady side wins ties.
    function automatic void merge_site(int s);
        logic [63:0] tv[Entries];
        logic [31:0] tc[Entries];
        int a, b;
        bit take_a;
        a = 0;
        b = Steady;
        for (int k = 0; k < Entries; k++) begin
            tv[k] = ent_val[s][k];
            tc[k] = ent_cnt[s][k];
        end
        for (int k = 0; k < Steady; k++) begin
            if (a >= Steady) take_a = 1'b0;
            else if (b >= Entries) take_a = 1'b1;
            else take_a = (tc[a] >= tc[b]);
            if (take_a) begin
                ent_val[s][k] = tv[a]; ent_cnt[s][k] = tc[a]; a++;
            end else begin
                ent_val[s][k] = tv[b]; ent_cnt[s][k] = tc[b]; b++;
            end
        end
        for (int k = Steady; k < Entries; k++) begin
            ent_val[s][k] = '0;
            ent_cnt[s][k] = '0;
        end
    endfunction

    function automatic t_out_beat predict_update(t_in_beat beat);
        t_out_beat r;
        int        s;
        logic [32:0] mid_sum;
        s = int'(beat.site_id) % Sites;
        // Middle steady counts are sampled before the counters move.
        mid_sum = {1'b0, ent_cnt[s][Steady/2]} + {1'b0, ent_cnt[s][Steady/2+1]};
        exec_cnt[s]  = sat_inc(exec_cnt[s]);
        clear_cnt[s] = sat_inc(clear_cnt[s]);
        r.merged = 1'b0;
        if ({1'b0, clear_cnt[s]} >= mid_sum) begin
            clear_cnt[s] = '0;
            merge_site(s);
            r.merged = 1'b1;
        end
        if (place_value(s, 0, Steady, beat.target_value)) r.placement = PlcSteady;
        else if (place_value(s, Steady, Entries, beat.target_value))
            r.placement = PlcClear;
        else r.placement = PlcDropped;
        r.exec_count = exec_cnt[s];
        r.top_value  = ent_val[s][0];
        r.top_count  = ent_cnt[s][0];
        return r;
    endfunction

    // Driver: takes the next beat once the current one is accepted, with
    // random idle bursts between beats.
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) result_q.push_back(predict_update(i_data));
            if (!i_valid || o_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_valid  <= 1'b0;
                end else if (send_q.size() > 0) begin
                    i_data  <= send_q.pop_front();
                    i_valid <= 1'b1;
                    if (!quiet && $urandom_range(0, 5) == 0)
                        send_gap <= $urandom_range(1, 14);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random stall bursts on the result side, in-order compare.
    int stall_left = 0;
    always @(posedge i_clk) begin
        t_out_beat exp_beat;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (result_q.size() == 0) begin
                    $display("%0t: result beat with nothing expected: %p", $time, o_data);
                    errors++;
                end else begin
                    exp_beat = result_q.pop_front();
                    if (o_data.exec_count !== exp_beat.exec_count) begin
                        $display("%0t: exec_count exp %0d got %0d", $time,
                                 exp_beat.exec_count, o_data.exec_count);
                        errors++;
                    end
                    if (o_data.top_value !== exp_beat.top_value) begin
                        $display("%0t: top_value exp %h got %h", $time,
                                 exp_beat.top_value, o_data.top_value);
                        errors++;
                    end
                    if (o_data.top_count !== exp_beat.top_count) begin
                        $display("%0t: top_count exp %0d got %0d", $time,
                                 exp_beat.top_count, o_data.top_count);
                        errors++;
                    end
                    if (o_data.placement !== exp_beat.placement) begin
                        $display("%0t: placement exp %0d got %0d", $time,
                                 exp_beat.placement, o_data.placement);
                        errors++;
                    end
                    if (o_data.merged !== exp_beat.merged) begin
                        $display("%0t: merged exp %0d got %0d", $time,
                                 exp_beat.merged, o_data.merged);
                        errors++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                i_ready    <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                stall_left <= $urandom_range(0, 13);
                i_ready    <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    function automatic t_in_beat mk_beat(logic [7:0] site, logic [63:0] val);
        t_in_beat b;
        b.site_id = site;
        b.target_value = val;
        return b;
    endfunction

    // Random values per hot site come from a small pool so matches, bubbling
    // and full tables happen often.
    logic [63:0] value_pool[16];
    logic [7:0]  hot_sites[6];

    initial begin
        t_in_beat b;
        int n;
        for (int s = 0; s < Sites; s++) begin
            exec_cnt[s] = '0;
            clear_cnt[s] = '0;
            for (int k = 0; k < Entries; k++) begin
                ent_val[s][k] = '0;
                ent_cnt[s][k] = '0;
            end
        end
        for (int k = 0; k < 16; k++) value_pool[k] = {$urandom, $urandom};
        for (int k = 0; k < 6; k++) hot_sites[k] = 8'($urandom_range(0, 255));

        // Directed: field extremes, zero value, repeats that bubble, and a
        // site flooded with distinct values until entries drop.
        send_q.push_back(mk_beat(8'd0, 64'd0));
        send_q.push_back(mk_beat(8'd255, 64'hFFFF_FFFF_FFFF_FFFF));
        send_q.push_back(mk_beat(8'd0, 64'd0));
        send_q.push_back(mk_beat(8'd255, 64'd1));
        send_q.push_back(mk_beat(8'd255, 64'd1));
        send_q.push_back(mk_beat(8'd255, 64'd1));
        for (int k = 0; k < 14; k++)
            send_q.push_back(mk_beat(8'd170, 64'h5555_0000_0000_0000 + k));
        send_q.push_back(mk_beat(8'd170, 64'h5555_0000_0000_000D));
        send_q.push_back(mk_beat(8'd85, 64'hAAAA_AAAA_AAAA_AAAA));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Hold the sender until the directed beats have all drained.
        wait (send_q.size() == 0 && !i_valid);
        wait (result_q.size() == 0);

        for (int it = 0; it < 1300; it++) begin
            n = $urandom_range(0, 99);
            if (n < 80) begin
                b.site_id = hot_sites[$urandom_range(0, 5)];
                b.target_value = value_pool[$urandom_range(0, 4 + (it % 12))];
            end else if (n < 90) begin
                b.site_id = hot_sites[$urandom_range(0, 5)];
                b.target_value = {$urandom, $urandom};
            end else begin
                b.site_id = 8'($urandom_range(0, 255));
                b.target_value = {$urandom, $urandom};
            end
            send_q.push_back(b);
        end

        wait (send_q.size() < 200);
        quiet = 1'b1;
        wait (send_q.size() == 0 && !i_valid);
        wait (result_q.size() == 0);
        repeat (100) @(posedge i_clk);
        if (errors == 0 && result_q.size() == 0)
            $display("[hot_target_value_tracker] OK");
        else
            $display("[hot_target_value_tracker] ERROR");
        $finish;
    end

    initial begin
        #30ms;
        $display("[hot_target_value_tracker] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
